// ===== rtl/elevator_scan_controller_assert.svh =====
// ----------------------------------------------------------------------------
// Elevator scan controller assertion macros
// Concurrent assertion shorthands, clocked on i_clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_SCAN_CONTROLLER_ASSERT_SVH
`define ELEVATOR_SCAN_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define ESC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// Elevator scan controller package
// Field widths, opcodes, status codes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int FLOORS_DEF = 10;

    localparam int OPCODE_W = 2;
    localparam int FLOOR_W  = 4;
    localparam int DATA_W   = 6;
    localparam int STATUS_W = 3;

    localparam logic [DATA_W-1:0] CAPACITY_RESET = DATA_W'(12);
    localparam logic [DATA_W-1:0] DATA_MAX       = '1;

    localparam logic [OPCODE_W-1:0] OP_PRESS  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DEPART = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ALARM  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PARTIAL = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HALTED  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TAKE,
        S_MERGE,
        S_LOAD,
        S_CLEAR,
        S_SCAN,
        S_DIST,
        S_ARRIVE,
        S_DONE
    } t_state;

endpackage

// ===== rtl/elevator_scan_controller.sv =====
// ----------------------------------------------------------------------------
// Elevator scan controller
// SCAN-ordered elevator car: floor presses, door-close departures and alarm,
// one result transaction per input transaction.
// ----------------------------------------------------------------------------
// One transaction is taken at a time; the input stalls until its result is
// registered. All arithmetic runs through a single 6-bit add/subtract unit
// stepped by the sequencer. A press runs decode, take, merge, load and done,
// or decode and done if the car is full or the floor rejected; an alarm or a
// halted-car request runs decode and done; a depart runs decode, clear, scan
// steps, where reaching the end of a sweep also costs a step, then distance
// and arrive at a pending floor, and done, then idle. A finished result waits
// in the output register while the next transaction is taken.
module elevator_scan_controller #(
    parameter int FLOORS = esc_pkg::FLOORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [esc_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [esc_pkg::FLOOR_W-1:0]   i_floor,
    input  logic [esc_pkg::DATA_W-1:0]    i_riders,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [esc_pkg::STATUS_W-1:0]  o_status,
    output logic [esc_pkg::DATA_W-1:0]    o_accepted,
    output logic [esc_pkg::DATA_W-1:0]    o_refused,
    output logic [esc_pkg::FLOOR_W-1:0]   o_car_floor,
    output logic                          o_going_up,
    output logic [esc_pkg::DATA_W-1:0]    o_rider_count,
    output logic [esc_pkg::FLOOR_W-1:0]   o_distance,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [esc_pkg::DATA_W-1:0]    i_cfg_data
);
    import esc_pkg::*;

    localparam int IDX_W = (FLOORS > 1) ? $clog2(FLOORS) : 1;

    t_state                r_state, n_state;
    logic [DATA_W-1:0]     r_capacity;
    logic [FLOORS-1:0]     r_pending, n_pending;
    logic [DATA_W-1:0]     r_drop [FLOORS];
    logic [DATA_W-1:0]     n_drop [FLOORS];
    logic [DATA_W-1:0]     r_load, n_load;
    logic                  r_heading, n_heading;
    logic [FLOOR_W-1:0]    r_position, n_position;
    logic                  r_halted, n_halted;

    logic [OPCODE_W-1:0]   r_op;
    logic [FLOOR_W-1:0]    r_floor;
    logic [DATA_W-1:0]     r_riders;
    logic [DATA_W-1:0]     r_room, n_room;
    logic [DATA_W-1:0]     r_acc, n_acc;
    logic [DATA_W-1:0]     r_ref, n_ref;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [FLOOR_W-1:0]    r_dist, n_dist;
    logic [FLOOR_W-1:0]    r_cursor, n_cursor;
    logic                  r_dir, n_dir;
    logic                  r_rev, n_rev;

    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [DATA_W-1:0]     r_out_acc, n_out_acc;
    logic [DATA_W-1:0]     r_out_ref, n_out_ref;
    logic [FLOOR_W-1:0]    r_out_floor, n_out_floor;
    logic                  r_out_up, n_out_up;
    logic [DATA_W-1:0]     r_out_load, n_out_load;
    logic [FLOOR_W-1:0]    r_out_dist, n_out_dist;

    logic                  in_take;
    logic [DATA_W-1:0]     alu_a, alu_b;
    logic                  alu_sub;
    logic [DATA_W:0]       alu_res;
    logic                  alu_borrow;
    logic [IDX_W-1:0]      drop_addr;
    logic [DATA_W-1:0]     drop_rd;
    logic                  full;
    logic                  reject;
    logic                  at_end;
    logic                  hit;
    logic                  out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    // shared add/subtract unit
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_DECODE: begin
                alu_a   = r_capacity;
                alu_b   = r_load;
                alu_sub = 1'b1;
            end
            S_TAKE: begin
                alu_a   = r_riders;
                alu_b   = r_room;
                alu_sub = 1'b1;
            end
            S_MERGE: begin
                alu_a = drop_rd;
                alu_b = r_acc;
            end
            S_LOAD: begin
                alu_a = r_load;
                alu_b = r_acc;
            end
            S_SCAN: begin
                alu_a   = DATA_W'(r_cursor);
                alu_b   = DATA_W'(1);
                alu_sub = !r_dir;
            end
            S_DIST: begin
                alu_a   = r_dir ? DATA_W'(r_cursor) : DATA_W'(r_position);
                alu_b   = r_dir ? DATA_W'(r_position) : DATA_W'(r_cursor);
                alu_sub = 1'b1;
            end
            S_ARRIVE: begin
                alu_a   = r_load;
                alu_b   = drop_rd;
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
        alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                             : ({1'b0, alu_a} + {1'b0, alu_b});
        alu_borrow = alu_res[DATA_W];
    end

    always_comb begin
        case (r_state)
            S_MERGE: drop_addr = r_floor[IDX_W-1:0];
            S_CLEAR: drop_addr = r_position[IDX_W-1:0];
            default: drop_addr = r_cursor[IDX_W-1:0];
        endcase
        drop_rd = r_drop[drop_addr];
        full    = alu_borrow || (alu_res[DATA_W-1:0] == '0);
        reject  = ({1'b0, r_floor} >= (FLOOR_W+1)'(FLOORS)) || (r_floor == r_position);
        at_end  = r_dir ? (r_cursor == FLOOR_W'(FLOORS - 1)) : (r_cursor == '0);
        hit     = r_pending[alu_res[IDX_W-1:0]];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_halted) begin
                    n_state = S_DONE;
                end else if (r_op == OP_PRESS) begin
                    n_state = (full || reject) ? S_DONE : S_TAKE;
                end else if (r_op == OP_DEPART) begin
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_TAKE:   n_state = S_MERGE;
            S_MERGE:  n_state = S_LOAD;
            S_LOAD:   n_state = S_DONE;
            S_CLEAR:  n_state = S_SCAN;
            S_SCAN: begin
                if (at_end) begin
                    if (r_rev) begin
                        n_state = S_DONE;
                    end
                end else if (hit) begin
                    n_state = S_DIST;
                end
            end
            S_DIST:   n_state = S_ARRIVE;
            S_ARRIVE: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_pending    = r_pending;
        n_drop       = r_drop;
        n_load       = r_load;
        n_heading    = r_heading;
        n_position   = r_position;
        n_halted     = r_halted;
        n_room       = r_room;
        n_acc        = r_acc;
        n_ref        = r_ref;
        n_status     = r_status;
        n_dist       = r_dist;
        n_cursor     = r_cursor;
        n_dir        = r_dir;
        n_rev        = r_rev;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_acc    = r_out_acc;
        n_out_ref    = r_out_ref;
        n_out_floor  = r_out_floor;
        n_out_up     = r_out_up;
        n_out_load   = r_out_load;
        n_out_dist   = r_out_dist;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                n_acc    = '0;
                n_ref    = '0;
                n_status = ST_OK;
                n_dist   = '0;
            end
            S_DECODE: begin
                if (r_halted) begin
                    n_status = ST_HALTED;
                end else if (r_op == OP_ALARM) begin
                    n_halted = 1'b1;
                    n_status = ST_HALTED;
                end else if (r_op == OP_PRESS) begin
                    if (full) begin
                        n_status = ST_FULL;
                        n_ref    = r_riders;
                    end else if (reject) begin
                        n_status = ST_REJECT;
                    end else begin
                        n_room = alu_res[DATA_W-1:0];
                    end
                end
            end
            S_TAKE: begin
                if (alu_borrow) begin
                    n_acc = r_riders;
                end else begin
                    n_acc = r_room;
                    n_ref = alu_res[DATA_W-1:0];
                    if (alu_res[DATA_W-1:0] != '0) begin
                        n_status = ST_PARTIAL;
                    end
                end
            end
            S_MERGE: begin
                n_drop[drop_addr]    = alu_res[DATA_W] ? DATA_MAX : alu_res[DATA_W-1:0];
                n_pending[drop_addr] = 1'b1;
            end
            S_LOAD: begin
                n_load = alu_res[DATA_W-1:0];
            end
            S_CLEAR: begin
                n_pending[drop_addr] = 1'b0;
                n_drop[drop_addr]    = '0;
                n_cursor             = r_position;
                n_dir                = r_heading;
                n_rev                = 1'b0;
            end
            S_SCAN: begin
                if (at_end) begin
                    if (!r_rev) begin
                        n_rev    = 1'b1;
                        n_dir    = !r_dir;
                        n_cursor = r_position;
                    end
                end else begin
                    n_cursor = alu_res[FLOOR_W-1:0];
                end
            end
            S_DIST: begin
                n_dist     = alu_res[FLOOR_W-1:0];
                n_position = r_cursor;
                n_heading  = r_dir;
            end
            S_ARRIVE: begin
                n_load               = alu_borrow ? '0 : alu_res[DATA_W-1:0];
                n_drop[drop_addr]    = '0;
                n_pending[drop_addr] = 1'b0;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_acc    = r_acc;
                    n_out_ref    = r_ref;
                    n_out_floor  = r_position;
                    n_out_up     = r_heading;
                    n_out_load   = r_load;
                    n_out_dist   = r_dist;
                end
            end
            default: begin
                n_out_valid = n_out_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= CAPACITY_RESET;
            r_pending   <= '0;
            r_load      <= '0;
            r_heading   <= 1'b1;
            r_position  <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int f = 0; f < FLOORS; f++) begin
                r_drop[f] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_drop      <= n_drop;
            r_load      <= n_load;
            r_heading   <= n_heading;
            r_position  <= n_position;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op     <= i_opcode;
            r_floor  <= i_floor;
            r_riders <= i_riders;
        end
        r_room       <= n_room;
        r_acc        <= n_acc;
        r_ref        <= n_ref;
        r_status     <= n_status;
        r_dist       <= n_dist;
        r_cursor     <= n_cursor;
        r_dir        <= n_dir;
        r_rev        <= n_rev;
        r_out_status <= n_out_status;
        r_out_acc    <= n_out_acc;
        r_out_ref    <= n_out_ref;
        r_out_floor  <= n_out_floor;
        r_out_up     <= n_out_up;
        r_out_load   <= n_out_load;
        r_out_dist   <= n_out_dist;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_accepted    = r_out_acc;
    assign o_refused     = r_out_ref;
    assign o_car_floor   = r_out_floor;
    assign o_going_up    = r_out_up;
    assign o_rider_count = r_out_load;
    assign o_distance    = r_out_dist;

`include "elevator_scan_controller_assert.svh"

    `ESC_ASSERT_NEXT(a_halt_sticky, r_halted, r_halted, "alarm latch released")
    `ESC_ASSERT_NEXT(a_halt_freeze_pos, r_halted, $stable(r_position), "halted car moved")
    `ESC_ASSERT_NEXT(a_halt_freeze_pend, r_halted, $stable(r_pending), "halted car took a request")
    `ESC_ASSERT_NOW(a_pos_range, 1'b1, {1'b0, r_position} < (FLOOR_W+1)'(FLOORS), "car beyond top floor")

endmodule
